// ===== hw/rtl/lrpa_pkg.sv =====
// Shared constants and helpers for the low-rank potential apply unit.
`default_nettype none
package lrpa_pkg;
  localparam int unsigned MaxGrid = 64;
  localparam int unsigned MaxRank = 32;
  localparam int unsigned GridW = $clog2(MaxGrid);
  localparam int unsigned RankW = $clog2(MaxRank);
  localparam int unsigned AddrW = GridW + RankW;

  localparam logic [1:0] OpLoadBasis = 2'd0;
  localparam logic [1:0] OpLoadEigen = 2'd1;
  localparam logic [1:0] OpPair      = 2'd2;

  localparam logic [0:0] CfgRank = 1'd0;
  localparam logic [0:0] CfgGrid = 1'd1;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/low_rank_potential_apply_unit.sv =====
// Top level of the low-rank potential apply unit.
// Input items arrive on in_valid_i/in_ready_o: opcode 0 loads a basis entry,
// opcode 1 an eigenvalue, opcode 2 a complex sample pair for one grid point.
// A load or an unused opcode leaves the sequencer idle. For a pair, one
// shared multiplier, followed by a register, does every product in turn; a
// pair outside the grid skips the projection update. A pair marked last then
// starts the output run: for each grid point the unit offers one item on
// out_valid_o/out_ready_i, and waits while the receiver stalls. After the
// run a clearing pass zeroes all 32 projection entries, so each set starts
// from zero. No input item is taken while a pair, a run or a clearing pass
// is in progress. Reset returns the sequencer to idle, the registers to
// rank 32 and grid 64, and starts the clearing pass; the basis and
// eigenvalue memories hold whatever was last written.
`default_nettype none
module low_rank_potential_apply_unit
  import lrpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [5:0]         grid_index_i,
  input  wire logic [4:0]         rank_index_i,
  input  wire logic signed [15:0] load_value_i,
  input  wire logic signed [15:0] first_re_i,
  input  wire logic signed [15:0] first_im_i,
  input  wire logic signed [15:0] second_re_i,
  input  wire logic signed [15:0] second_im_i,
  input  wire logic               last_pair_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [5:0]              out_index_o,
  output logic signed [31:0]      pot_re_o,
  output logic signed [31:0]      pot_im_o,
  output logic                    end_of_run_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StW    = 4'd1;
  localparam logic [3:0] StWFin = 4'd2;
  localparam logic [3:0] StPRd  = 4'd3;
  localparam logic [3:0] StPMul = 4'd4;
  localparam logic [3:0] StPAcc = 4'd5;
  localparam logic [3:0] StORd  = 4'd6;
  localparam logic [3:0] StOC   = 4'd7;
  localparam logic [3:0] StOMul = 4'd8;
  localparam logic [3:0] StOAcc = 4'd9;
  localparam logic [3:0] StOut  = 4'd10;

  logic [3:0] state_q;
  logic [5:0] rank_cfg_q;
  logic [6:0] grid_cfg_q;
  logic [RankW:0] nr;
  logic [6:0] ng;

  always_comb begin
    if (rank_cfg_q == 6'd0) nr = (RankW+1)'(1);
    else if ({1'b0, rank_cfg_q} > 7'(MaxRank)) nr = (RankW+1)'(MaxRank);
    else nr = (RankW+1)'(rank_cfg_q);
    if (grid_cfg_q < 7'd2) ng = 7'd2;
    else if (grid_cfg_q > 7'(MaxGrid)) ng = 7'(MaxGrid);
    else ng = grid_cfg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_cfg_q <= 6'd32;
      grid_cfg_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRank: rank_cfg_q <= cfg_data_i[5:0];
        CfgGrid: grid_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memories.
  logic signed [15:0] basis_mem [MaxGrid*MaxRank];
  logic signed [15:0] eigen_mem [MaxRank];
  logic signed [31:0] proj_re_mem [MaxRank];
  logic signed [31:0] proj_im_mem [MaxRank];
  logic signed [15:0] basis_rd_q, eigen_rd_q;
  logic signed [31:0] pre_rd_q, pim_rd_q;
  logic [AddrW-1:0] basis_ra;
  logic [RankW-1:0] rank_ra;
  logic proj_we;
  logic [RankW-1:0] proj_wa;
  logic signed [31:0] proj_wre, proj_wim;

  logic accept;
  logic clr_busy_q;
  logic clr_start;
  assign in_ready_o = (state_q == StIdle) && !clr_busy_q;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == OpLoadBasis && {1'b0, rank_index_i} < 6'(MaxRank))
      basis_mem[{grid_index_i, rank_index_i}] <= load_value_i;
    if (accept && opcode_i == OpLoadEigen)
      eigen_mem[rank_index_i] <= load_value_i;
    basis_rd_q <= basis_mem[basis_ra];
    eigen_rd_q <= eigen_mem[rank_ra];
  end

  // Projection memory with a clearing pass after reset and after every run.
  logic [RankW:0] clr_cnt_q;
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      proj_re_mem[clr_cnt_q[RankW-1:0]] <= '0;
      proj_im_mem[clr_cnt_q[RankW-1:0]] <= '0;
    end else if (proj_we) begin
      proj_re_mem[proj_wa] <= proj_wre;
      proj_im_mem[proj_wa] <= proj_wim;
    end
    pre_rd_q <= proj_re_mem[rank_ra];
    pim_rd_q <= proj_im_mem[rank_ra];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == (RankW+1)'(MaxRank-1)) clr_busy_q <= 1'b0;
    end else if (clr_start) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q <= '0;
    end
  end

  // Datapath registers.
  logic [5:0] gi_q;
  logic [RankW-1:0] m_q;
  logic [5:0] i_q;
  logic [2:0] ph_q;
  logic last_q;
  logic signed [15:0] ar_q, ai_q, br_q, bi_q;
  logic signed [49:0] t_q;
  logic signed [31:0] wr_q, wi_q;
  logic signed [31:0] c_q;
  logic signed [31:0] acc_re_q, acc_im_q;
  logic signed [31:0] tre_q;

  logic signed [31:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [49:0] mac_p;
  lrpa_mac u_mac (.clk_i(clk_i), .a_i(mac_a), .b_i(mac_b), .p_o(mac_p));

  assign basis_ra = (state_q inside {StORd, StOC, StOMul, StOAcc}) ? {i_q, m_q} : {gi_q, m_q};
  assign rank_ra = m_q;
  logic m_last;
  assign m_last = ({1'b0, m_q} == nr - 1'b1);
  assign clr_start = (state_q == StOut) && (!out_valid_o || out_ready_i) &&
                     ({1'b0, i_q} == ng - 1'b1);

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    proj_we = 1'b0;
    proj_wa = m_q;
    proj_wre = pre_rd_q;
    proj_wim = pim_rd_q;
    unique case (state_q)
      StW: begin
        unique case (ph_q)
          3'd0: begin mac_a = {{2{ar_q[15]}}, ar_q, 14'd0}; mac_b = 18'(br_q); end
          3'd1: begin mac_a = {{2{ai_q[15]}}, ai_q, 14'd0}; mac_b = 18'(bi_q); end
          3'd2: begin mac_a = {{2{ar_q[15]}}, ar_q, 14'd0}; mac_b = 18'(bi_q); end
          default: begin mac_a = {{2{ai_q[15]}}, ai_q, 14'd0}; mac_b = 18'(br_q); end
        endcase
      end
      StPMul: begin
        mac_a = (ph_q == 3'd0) ? wr_q : wi_q;
        mac_b = 18'(basis_rd_q);
      end
      StPAcc: begin
        proj_we = 1'b1;
        proj_wre = sat32(50'(pre_rd_q) + 50'(tre_q));
        proj_wim = sat32(50'(pim_rd_q) + mac_p);
      end
      StOC: begin mac_a = 32'(eigen_rd_q); mac_b = 18'(basis_rd_q); end
      StOMul: begin
        mac_a = (ph_q == 3'd1) ? pre_rd_q : pim_rd_q;
        mac_b = 18'(c_q);
      end
      default: ;
    endcase
  end

  logic last_gi_ok;
  assign last_gi_ok = ({1'b0, gi_q} < ng);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      out_index_o <= '0;
      pot_re_o <= '0;
      pot_im_o <= '0;
      end_of_run_o <= 1'b0;
      ph_q <= '0;
      m_q <= '0;
      i_q <= '0;
      last_q <= 1'b0;
      gi_q <= '0;
      ar_q <= '0;
      ai_q <= '0;
      br_q <= '0;
      bi_q <= '0;
      t_q <= '0;
      wr_q <= '0;
      wi_q <= '0;
      c_q <= '0;
      acc_re_q <= '0;
      acc_im_q <= '0;
      tre_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != StOut) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept && opcode_i == OpPair && !clr_busy_q) begin
            gi_q <= grid_index_i;
            ar_q <= first_re_i; ai_q <= first_im_i;
            br_q <= second_re_i; bi_q <= second_im_i;
            last_q <= last_pair_i;
            ph_q <= '0;
            m_q <= '0;
            state_q <= StW;
          end
        end
        StW: begin
          unique case (ph_q)
            3'd0: ph_q <= 3'd1;
            3'd1: begin t_q <= mac_p; ph_q <= 3'd2; end
            3'd2: begin wr_q <= 32'((t_q + mac_p) >>> 14); ph_q <= 3'd3; end
            3'd3: begin t_q <= mac_p; ph_q <= 3'd4; end
            default: begin
              wi_q <= 32'((t_q - mac_p) >>> 14);
              ph_q <= '0;
              state_q <= last_gi_ok ? StPRd : StWFin;
            end
          endcase
        end
        StWFin: begin
          m_q <= '0; i_q <= '0; ph_q <= '0;
          state_q <= last_q ? StORd : StIdle;
        end
        StPRd: begin ph_q <= '0; state_q <= StPMul; end
        StPMul: begin
          if (ph_q == 3'd0) begin
            ph_q <= 3'd1;
          end else begin
            tre_q <= 32'(mac_p);
            state_q <= StPAcc;
          end
        end
        StPAcc: begin
          if (m_last) state_q <= StWFin;
          else begin m_q <= m_q + 1'b1; state_q <= StPRd; end
        end
        StORd: begin
          if (m_q == '0) begin acc_re_q <= '0; acc_im_q <= '0; end
          state_q <= StOC;
        end
        StOC: begin ph_q <= 3'd0; state_q <= StOMul; end
        StOMul: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd0) c_q <= 32'(mac_p);
          if (ph_q == 3'd2) tre_q <= sat32(mac_p);
          if (ph_q == 3'd3) state_q <= StOAcc;
        end
        StOAcc: begin
          acc_re_q <= sat32(50'(acc_re_q) + 50'(tre_q));
          acc_im_q <= sat32(50'(acc_im_q) + 50'(sat32(mac_p)));
          if (m_last) state_q <= StOut;
          else begin m_q <= m_q + 1'b1; state_q <= StORd; end
        end
        StOut: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            out_index_o <= i_q;
            pot_re_o <= acc_re_q;
            pot_im_o <= acc_im_q;
            end_of_run_o <= ({1'b0, i_q} == ng - 1'b1);
            m_q <= '0;
            if ({1'b0, i_q} == ng - 1'b1) begin
              state_q <= StIdle;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= StORd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lrpa_mac.sv =====
// Shared signed multiplier with floor rescale by 2^14, registered.
`default_nettype none
module lrpa_mac
  import lrpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [17:0] b_i,
  output logic signed [49:0]      p_o
);
  logic signed [49:0] prod;
  assign prod = 50'(a_i * b_i);
  always_ff @(posedge clk_i) begin
    p_o <= prod >>> 14;
  end
endmodule
`default_nettype wire
